[src/cpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the complex-to-polar converter: widths, CORDIC constants and
// the arctangent table. No dependencies.
package cpc_pkg;

   localparam int DATA_WIDTH_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // extra fraction bits carried through the rotations
   localparam int GUARD_BITS = 8;
   // headroom for CORDIC growth (about 1.65 * sqrt(2))
   localparam int GROWTH_BITS = 3;

   // gain compensation 0.60725 in units of 2^-32
   localparam logic [31:0] GAIN_K   = 32'h9B74_EDA8;
   // pi in the 32-bit angle unit (2^32 = 2*pi)
   localparam logic [31:0] ANGLE_PI = 32'h8000_0000;

   // atan(2^-i) in the 32-bit angle unit, rounded
   function automatic logic [31:0] atan_angle(input int idx);
      logic [31:0] a;
      case (idx)
         0:  a = 32'd536870912;
         1:  a = 32'd316933406;
         2:  a = 32'd167458907;
         3:  a = 32'd85004756;
         4:  a = 32'd42667331;
         5:  a = 32'd21354465;
         6:  a = 32'd10679838;
         7:  a = 32'd5340245;
         8:  a = 32'd2670163;
         9:  a = 32'd1335087;
         10: a = 32'd667544;
         11: a = 32'd333772;
         12: a = 32'd166886;
         13: a = 32'd83443;
         14: a = 32'd41722;
         15: a = 32'd20861;
         16: a = 32'd10430;
         17: a = 32'd5215;
         18: a = 32'd2608;
         19: a = 32'd1304;
         20: a = 32'd652;
         21: a = 32'd326;
         22: a = 32'd163;
         23: a = 32'd81;
         24: a = 32'd41;
         25: a = 32'd20;
         26: a = 32'd10;
         27: a = 32'd5;
         28: a = 32'd3;
         29: a = 32'd1;
         30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

[src/cpc_pre.sv]
`timescale 1ns / 1ps
// Entry stage: scales the sample by the guard bits and folds the left half
// plane onto the right one. Depends on cpc_pkg.
module cpc_pre #(
   parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF,
   parameter int XW         = DATA_WIDTH + cpc_pkg::GUARD_BITS + cpc_pkg::GROWTH_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] in_re,
   input  logic signed [DATA_WIDTH-1:0] in_im,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [XW-1:0]         out_x,
   output logic signed [XW-1:0]         out_y,
   output logic [31:0]                  out_z,
   output logic                         out_zero
);
   import cpc_pkg::*;

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff, y_ff, x_in, y_in;
   logic [31:0]          z_ff, z_in;
   logic                 zero_ff, zero_in;
   logic signed [XW-1:0] re_s, im_s;

   assign re_s = XW'(in_re) <<< GUARD_BITS;
   assign im_s = XW'(in_im) <<< GUARD_BITS;

   always_comb begin
      zero_in = (in_re == '0) && (in_im == '0);
      if (in_re[DATA_WIDTH-1]) begin
         x_in = -re_s;
         y_in = -im_s;
         z_in = ANGLE_PI;
      end else begin
         x_in = re_s;
         y_in = im_s;
         z_in = 32'd0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= zero_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_zero  = zero_ff;

endmodule

[src/cpc_cell.sv]
`timescale 1ns / 1ps
// One CORDIC vectoring cell: a single micro-rotation by atan(2^-STAGE)
// toward the real axis, registered. Depends on cpc_pkg.
module cpc_cell #(
   parameter int STAGE = 0,
   parameter int XW    = cpc_pkg::DATA_WIDTH_DEF + cpc_pkg::GUARD_BITS + cpc_pkg::GROWTH_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic [31:0]          in_z,
   input  logic                 in_zero,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output logic [31:0]          out_z,
   output logic                 out_zero
);
   import cpc_pkg::*;

   localparam logic [31:0] ATAN = atan_angle(STAGE);

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff, y_ff, x_in, y_in, xs, ys;
   logic [31:0]          z_ff, z_in;
   logic                 zero_ff;

   // arithmetic shifts: floor rounding
   assign xs = in_x >>> STAGE;
   assign ys = in_y >>> STAGE;

   always_comb begin
      if (!in_y[XW-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_zero  = zero_ff;

endmodule

[src/cpc_gain.sv]
`timescale 1ns / 1ps
// Gain compensation and output stage: 64x32 product split in two 32x32
// partial products, then add, round, saturate; phase rounding. Depends on cpc_pkg.
module cpc_gain #(
   parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF,
   parameter int XW         = DATA_WIDTH + cpc_pkg::GUARD_BITS + cpc_pkg::GROWTH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [XW-1:0]   in_x,
   input  logic [31:0]            in_z,
   input  logic                   in_zero,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [DATA_WIDTH-1:0]  out_amp,
   output logic [DATA_WIDTH-1:0]  out_phase
);
   import cpc_pkg::*;

   localparam int          ZSHIFT = 32 - DATA_WIDTH;
   localparam logic [31:0] ZRND   = (ZSHIFT > 0) ? (32'd1 << (ZSHIFT - 1)) : 32'd0;
   localparam logic [63:0] ARND   = 64'd1 << (GUARD_BITS - 1);

   // product stage
   logic        pv_ff;
   logic [63:0] plo_ff, phi_ff;
   logic [31:0] pz_ff;
   logic        pzero_ff;
   logic [63:0] ux;
   logic        p_ready;

   // output stage
   logic                  ov_ff;
   logic [DATA_WIDTH-1:0] amp_ff, amp_in, ph_ff, ph_in;
   logic [63:0]           t_sum, a_full;
   logic [31:0]           z_sum;
   logic                  o_ready;

   // negative x cannot occur after the fold, clamp anyway
   assign ux = in_x[XW-1] ? 64'd0 : 64'(unsigned'(in_x));

   assign o_ready  = !ov_ff || out_ready;
   assign p_ready  = !pv_ff || o_ready;
   assign in_ready = p_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            pv_ff <= in_valid;
         end
         if (o_ready) begin
            ov_ff <= pv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && in_valid) begin
         plo_ff   <= 64'(ux[31:0]) * 64'(GAIN_K);
         phi_ff   <= 64'(ux[63:32]) * 64'(GAIN_K);
         pz_ff    <= in_z;
         pzero_ff <= in_zero;
      end
   end

   always_comb begin
      t_sum  = phi_ff + {32'd0, plo_ff[63:32]};
      a_full = (t_sum + ARND) >> GUARD_BITS;
      z_sum  = pz_ff + ZRND;
      if (pzero_ff) begin
         amp_in = '0;
         ph_in  = '0;
      end else begin
         if (|a_full[63:DATA_WIDTH]) begin
            amp_in = '1;
         end else begin
            amp_in = a_full[DATA_WIDTH-1:0];
         end
         ph_in = z_sum[31 -: DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && pv_ff) begin
         amp_ff <= amp_in;
         ph_ff  <= ph_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_amp   = amp_ff;
   assign out_phase = ph_ff;

endmodule

[src/complex_to_polar_converter_top.sv]
`timescale 1ns / 1ps
// Top level of the complex-to-polar converter (CORDIC vectoring, gain
// compensated). Depends on cpc_pkg, cpc_pre, cpc_cell and cpc_gain.
//
//  channel | direction | beat contents
//  --------+-----------+----------------------------------------------
//  req_    | in        | req_real_part, req_imag_part (signed)
//  rsp_    | out       | rsp_amplitude (unsigned), rsp_phase_angle (signed)
//
// One beat in and one beat out per cycle when nothing stalls. Each beat
// passes the fold stage, one register per CORDIC cell, the partial-product
// register and the output register, in that order.
// Synchronous active-high reset clears only the valid bits of the chain.
// Every stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles collapse and req_ready stays high while a
// finished beat waits on rsp_ready, until the chain is full.
module complex_to_polar_converter_top #(
   parameter int DATA_WIDTH    = cpc_pkg::DATA_WIDTH_DEF,
   parameter int CORDIC_STAGES = cpc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_real_part,
   input  logic signed [DATA_WIDTH-1:0] req_imag_part,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DATA_WIDTH-1:0]        rsp_amplitude,
   output logic signed [DATA_WIDTH-1:0] rsp_phase_angle
);
   import cpc_pkg::*;

   // x/y width: sample, guard bits and CORDIC growth
   localparam int XW = DATA_WIDTH + GUARD_BITS + GROWTH_BITS;

   // chain taps: index 0 is the fold stage output, index k the k-th cell output
   logic                 ch_valid [0:CORDIC_STAGES];
   logic                 ch_ready [0:CORDIC_STAGES];
   logic signed [XW-1:0] ch_x     [0:CORDIC_STAGES];
   logic signed [XW-1:0] ch_y     [0:CORDIC_STAGES];
   logic [31:0]          ch_z     [0:CORDIC_STAGES];
   logic                 ch_zero  [0:CORDIC_STAGES];

   logic [DATA_WIDTH-1:0] amp_w, ph_w;

   // fold left half plane onto right, scale by guard bits
   cpc_pre #(
      .DATA_WIDTH (DATA_WIDTH),
      .XW         (XW)
   ) u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_re     (req_real_part),
      .in_im     (req_imag_part),
      .out_valid (ch_valid[0]),
      .out_ready (ch_ready[0]),
      .out_x     (ch_x[0]),
      .out_y     (ch_y[0]),
      .out_z     (ch_z[0]),
      .out_zero  (ch_zero[0])
   );

   // row of micro-rotation cells
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      cpc_cell #(
         .STAGE (k),
         .XW    (XW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[k]),
         .in_ready  (ch_ready[k]),
         .in_x      (ch_x[k]),
         .in_y      (ch_y[k]),
         .in_z      (ch_z[k]),
         .in_zero   (ch_zero[k]),
         .out_valid (ch_valid[k+1]),
         .out_ready (ch_ready[k+1]),
         .out_x     (ch_x[k+1]),
         .out_y     (ch_y[k+1]),
         .out_z     (ch_z[k+1]),
         .out_zero  (ch_zero[k+1])
      );
   end

   // gain compensation, rounding, saturation; holds the output register.
   // y of the last cell is not needed.
   cpc_gain #(
      .DATA_WIDTH (DATA_WIDTH),
      .XW         (XW)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ch_valid[CORDIC_STAGES]),
      .in_ready  (ch_ready[CORDIC_STAGES]),
      .in_x      (ch_x[CORDIC_STAGES]),
      .in_z      (ch_z[CORDIC_STAGES]),
      .in_zero   (ch_zero[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_amp   (amp_w),
      .out_phase (ph_w)
   );

   assign rsp_amplitude   = amp_w;
   assign rsp_phase_angle = signed'(ph_w);

endmodule

[tb/tb_complex_to_polar_converter_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for complex_to_polar_converter_top: directed and random
// samples, with a bit-exact CORDIC predictor and a scoreboard. Depends on cpc_pkg.
module tb_complex_to_polar_converter_top;

   import cpc_pkg::*;

   localparam int DW      = DATA_WIDTH_DEF;
   localparam int STAGES  = CORDIC_STAGES_DEF;
   // pipeline depth: the fold stage, the cells, the product and the output register
   localparam int LATENCY = STAGES + 3;
   localparam int ANGLE_SHIFT = 32 - DW;
   localparam int RANDOM_PER_PHASE = 275;

   typedef struct packed {
      logic [DW-1:0]        amplitude;
      logic signed [DW-1:0] phase_angle;
   } polar_type;

   // Expected polar results in acceptance order. The predictor mirrors the
   // vectoring CORDIC: guard bits, fold into the right half plane, floor
   // shifts, 32-bit angle accumulator, gain scaling and rounding.
   class polar_scoreboard_type;
      polar_type pending_polar[$];
      int        errors = 0;

      static function automatic logic [31:0] arctan_step(int k);
         case (k)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335087;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41722;
            15: return 32'd20861;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2608;
            19: return 32'd1304;
            20: return 32'd652;
            21: return 32'd326;
            22: return 32'd163;
            23: return 32'd81;
            24: return 32'd41;
            25: return 32'd20;
            26: return 32'd10;
            27: return 32'd5;
            28: return 32'd3;
            29: return 32'd1;
            30: return 32'd1;
            default: return 32'd0;
         endcase
      endfunction

      static function automatic polar_type cordic_polar(logic signed [DW-1:0] re,
                                                        logic signed [DW-1:0] im);
         longint      x;
         longint      y;
         longint      xn;
         logic [31:0] z;
         logic [63:0] ux;
         logic [63:0] t;
         logic [63:0] amp;
         logic [63:0] ph;
         logic [63:0] mask;
         polar_type   res;
         mask = (64'd1 << DW) - 64'd1;
         res  = '0;
         if (re == 0 && im == 0)
            return res;
         x = longint'(re) * (longint'(1) << GUARD_BITS);
         y = longint'(im) * (longint'(1) << GUARD_BITS);
         z = 32'd0;
         // left half plane: rotate by pi first
         if (x < 0) begin
            x = -x;
            y = -y;
            z = ANGLE_PI;
         end
         for (int k = 0; k < STAGES && k < 32; k++) begin
            if (y >= 0) begin
               xn = x + (y >>> k);
               y  = y - (x >>> k);
               z  = z + arctan_step(k);
            end else begin
               xn = x - (y >>> k);
               y  = y + (x >>> k);
               z  = z - arctan_step(k);
            end
            x = xn;
         end
         ux  = (x < 0) ? 64'd0 : 64'(x);
         t   = (ux >> 32) * 64'(GAIN_K) + (((ux & 64'hFFFF_FFFF) * 64'(GAIN_K)) >> 32);
         amp = (t + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
         if (amp > mask)
            amp = mask;
         if (ANGLE_SHIFT > 0)
            ph = (64'(z) + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
         else
            ph = 64'(z);
         res.amplitude   = amp[DW-1:0];
         res.phase_angle = ph[DW-1:0];
         return res;
      endfunction

      function void note_sample(logic signed [DW-1:0] re, logic signed [DW-1:0] im);
         pending_polar.push_back(cordic_polar(re, im));
      endfunction

      function void check_polar(logic [DW-1:0] amp, logic signed [DW-1:0] ph);
         polar_type exp_p;
         if (pending_polar.size() == 0) begin
            $error("rsp beat with nothing pending: amplitude %0d phase_angle %0d", amp, ph);
            errors++;
            return;
         end
         exp_p = pending_polar.pop_front();
         if (amp !== exp_p.amplitude) begin
            $error("amplitude: expected %0d, got %0d", exp_p.amplitude, amp);
            errors++;
         end
         if (ph !== exp_p.phase_angle) begin
            $error("phase_angle: expected %0d, got %0d", exp_p.phase_angle, ph);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_polar.size();
      endfunction
   endclass

   // all inputs known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [DW-1:0] req_real_part = '0;
   logic signed [DW-1:0] req_imag_part = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DW-1:0]        rsp_amplitude;
   logic signed [DW-1:0] rsp_phase_angle;

   // idle percentages of the current phase
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   polar_scoreboard_type sb = new();

   complex_to_polar_converter_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_real_part  (req_real_part),
      .req_imag_part  (req_imag_part),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_amplitude  (rsp_amplitude),
      .rsp_phase_angle(rsp_phase_angle)
   );

   always #5 clock = ~clock;

   // Receiver: ready redrawn every cycle. Sampling right after the edge sees
   // pre-edge values since every drive here is nonblocking.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Result monitor: one beat per edge with valid and ready both high.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_polar(rsp_amplitude, rsp_phase_angle);
   end

   // Present one sample, with random idle cycles ahead of it, and hold it
   // until the edge that accepts it. Only one nonblocking write per signal
   // per step: the next call either idles or presents at once.
   task automatic send_sample(logic signed [DW-1:0] re, logic signed [DW-1:0] im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_sample(re, im);
   endtask

   // Random sample with a bias toward the corners of the CORDIC.
   task automatic send_random_sample();
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic signed [DW-1:0] corner[6];
      corner = '{-32768, -32767, -1, 0, 1, 32767};
      case ($urandom_range(9))
         6: begin
            // on an axis
            re = DW'($urandom);
            im = 0;
            if ($urandom_range(1)) begin
               im = re;
               re = 0;
            end
         end
         4, 5: begin
            // tiny vectors: rounding and shift flooring dominate
            re = DW'($urandom_range(127) - 64);
            im = DW'($urandom_range(127) - 64);
         end
         7: begin
            re = corner[$urandom_range(5)];
            im = corner[$urandom_range(5)];
         end
         8: begin
            // near the negative real axis, where the angle wraps at pi
            re = DW'(-$signed({1'b0, 15'($urandom)}) - 1);
            im = DW'($urandom_range(4) - 2);
         end
         9: begin
            // diagonals
            re = DW'($urandom);
            im = $urandom_range(1) ? re : -re;
         end
         default: begin
            re = DW'($urandom);
            im = DW'($urandom);
         end
      endcase
      send_sample(re, im);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero, axes, extremes, the pi wrap and tiny vectors.
      send_sample(0, 0);
      send_sample(32767, 0);
      send_sample(-32768, 0);
      send_sample(-1, 0);
      send_sample(1, 0);
      send_sample(0, 32767);
      send_sample(0, -32768);
      send_sample(0, 1);
      send_sample(0, -1);
      send_sample(32767, 32767);
      send_sample(-32768, -32768);
      send_sample(-32768, 32767);
      send_sample(32767, -32768);
      send_sample(-32768, -1);
      send_sample(-32768, 1);
      send_sample(-1, -1);
      send_sample(-1, 1);
      send_sample(1, -1);
      send_sample(1, 1);
      send_sample(-100, -1);
      send_sample(-100, 1);
      send_sample(12345, -23456);

      // Random phases: no idling, sender idle, receiver stalling, both light.
      for (int ph_i = 0; ph_i < 4; ph_i++) begin
         case (ph_i)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         repeat (RANDOM_PER_PHASE)
            send_random_sample();
      end
      req_valid <= 1'b0;

      // drain, then leave room for any stray beat
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of about 1100 beats under heavy idling.
   initial begin
      #(5_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
src/cpc_pkg.sv
src/cpc_pre.sv
src/cpc_cell.sv
src/cpc_gain.sv
src/complex_to_polar_converter_top.sv
tb/tb_complex_to_polar_converter_top.sv
